FILE: hdl/sqmd_pkg.sv
// shared types and elaboration-time constant functions for the qam mapper/demapper
package sqmd_pkg;

	// operation codes carried in tuser
	typedef enum logic {
		KIND_MAP   = 1'b0,
		KIND_DEMAP = 1'b1
	} kind_t;

	// order codes of the configuration register
	localparam logic [1:0] ORDER_4   = 2'd0;
	localparam logic [1:0] ORDER_16  = 2'd1;
	localparam logic [1:0] ORDER_64  = 2'd2;
	localparam logic [1:0] ORDER_RST = ORDER_16;

	// largest axis size and its index width
	localparam int MAX_L = 8;
	localparam int AXW   = 3;

	// floor square root, used for constants only
	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		longint unsigned x;
		r = 0;
		b = 64'd1 << 62;
		x = n;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit-power scale for a given axis bit count
	function automatic longint scale_of(int fb, int kb);
		longint unsigned num;
		longint unsigned q;
		num = 64'd1 << (2 * (fb + 1));
		unique case (kb)
			1:       q = num / 2;
			2:       q = num / 10;
			default: q = num / 42;
		endcase
		return longint'((isqrt(q) + 1) / 2);
	endfunction

	// saturated coordinate of grid position k on one axis
	function automatic longint point_of(int sw, int fb, int kb, int k);
		longint l;
		longint v;
		longint hi;
		l  = longint'(1) << kb;
		v  = ((l - 1) - 2 * longint'(k)) * scale_of(fb, kb);
		hi = (longint'(1) << (sw - 1)) - 1;
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v;
	endfunction

endpackage

FILE: hdl/sqmd_axis.sv
// per-axis nearest grid position search: distance stage and two registered min stages
module sqmd_axis #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [1:0]                     kb_sel,
	input  logic signed [SAMPLE_WIDTH-1:0] smp,
	output logic [sqmd_pkg::AXW-1:0]       idx
);

	localparam int SW = SAMPLE_WIDTH;

	typedef struct packed {
		logic [SW:0]              d;
		logic [sqmd_pkg::AXW-1:0] i;
	} cand_t;

	logic signed [SW-1:0] pts [3][sqmd_pkg::MAX_L];

	// constant point table, one row per order
	for (genvar m = 0; m < 3; m++) begin : g_ord
		for (genvar k = 0; k < sqmd_pkg::MAX_L; k++) begin : g_pt
			assign pts[m][k] = SW'(sqmd_pkg::point_of(SW, FRAC_BITS, m + 1, k));
		end
	end

	cand_t dist_s2 [sqmd_pkg::MAX_L];
	cand_t half_s3 [2];
	cand_t best_s4;

	logic [3:0]  lcnt;
	cand_t       dist_d [sqmd_pkg::MAX_L];
	cand_t       l1 [4];
	cand_t       l2 [2];
	logic [SW:0] diff [sqmd_pkg::MAX_L];

	assign lcnt = 4'd2 << kb_sel;

	// absolute distance to every candidate, unused ones pushed to the top
	always_comb begin
		for (int k = 0; k < sqmd_pkg::MAX_L; k++) begin
			diff[k] = {smp[SW-1], smp} - {pts[kb_sel][k][SW-1], pts[kb_sel][k]};
			dist_d[k].i = sqmd_pkg::AXW'(k);
			if (4'(k) < lcnt)
				dist_d[k].d = diff[k][SW] ? -diff[k] : diff[k];
			else
				dist_d[k].d = '1;
		end
	end

	// two tree levels, lower index kept on a tie
	always_comb begin
		for (int k = 0; k < 4; k++)
			l1[k] = (dist_s2[2*k+1].d < dist_s2[2*k].d) ? dist_s2[2*k+1] : dist_s2[2*k];
		for (int k = 0; k < 2; k++)
			l2[k] = (l1[2*k+1].d < l1[2*k].d) ? l1[2*k+1] : l1[2*k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s2 <= dist_d;
			half_s3 <= l2;
			best_s4 <= (half_s3[1].d < half_s3[0].d) ? half_s3[1] : half_s3[0];
		end
	end

	assign idx = best_s4.i;

endmodule

FILE: hdl/square_qam_mapper_demapper_top.sv
// top level of the square qam mapper and hard-decision demapper
//
// channel | dir | words                         | tdata / tuser
// s_      | in  | map index or received sample  | symbol_in, re_in, im_in / kind
// m_      | out | mapped point or decided index | re_out, im_out, symbol_out
// cfg_    | in  | order_mode write              | cfg_wdata
//
// four register stages: input, distance, two-level min, final min and output
// one word per cycle unless output stalls; m_tvalid is the final stage valid
// the whole pipeline advances together; a stalled output holds every stage
// arst_n clears the valid bits and sets the order to 16-QAM
module square_qam_mapper_demapper_top #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// symbol_in, re_in, im_in, zero fill
	input  logic [((2 * SAMPLE_WIDTH + 6 + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                 s_tuser,   // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// re_out, im_out, symbol_out, zero fill
	output logic [((2 * SAMPLE_WIDTH + 6 + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int DW = ((2 * SW + 6 + 7) / 8) * 8;
	localparam int AXW = sqmd_pkg::AXW;

	logic [1:0] order_q;

	// order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) order_q <= sqmd_pkg::ORDER_RST;
		else if (cfg_we) order_q <= cfg_wdata;
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	assign en       = !v_s4 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	sqmd_pkg::kind_t      kind_s1, kind_s2, kind_s3, kind_s4;
	logic [5:0]           sym_s1;
	logic signed [SW-1:0] re_s1, im_s1;
	logic [1:0]           kb_s1, kb_s2, kb_s3, kb_s4;
	logic signed [SW-1:0] mre_s2, mim_s2, mre_s3, mim_s3, mre_s4, mim_s4;

	logic signed [SW-1:0] pts [3][sqmd_pkg::MAX_L];

	// constant point table for the map path
	for (genvar m = 0; m < 3; m++) begin : g_ord
		for (genvar k = 0; k < sqmd_pkg::MAX_L; k++) begin : g_pt
			assign pts[m][k] = SW'(sqmd_pkg::point_of(SW, FRAC_BITS, m + 1, k));
		end
	end

	logic [AXW-1:0] lmask, row_d, col_d;
	assign lmask = AXW'((4'd2 << kb_s1) - 4'd1);
	assign row_d = AXW'(sym_s1 >> ({1'b0, kb_s1} + 3'd1)) & lmask;
	assign col_d = sym_s1[AXW-1:0] & lmask;

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= sqmd_pkg::kind_t'(s_tuser);
			sym_s1  <= s_tdata[5:0];
			re_s1   <= s_tdata[6 +: SW];
			im_s1   <= s_tdata[6 + SW +: SW];
			kb_s1   <= order_q[1] ? sqmd_pkg::ORDER_64 : order_q;

			kind_s2 <= kind_s1;
			kb_s2   <= kb_s1;
			mre_s2  <= (kind_s1 == sqmd_pkg::KIND_MAP) ? pts[kb_s1][row_d] : '0;
			mim_s2  <= (kind_s1 == sqmd_pkg::KIND_MAP) ? pts[kb_s1][col_d] : '0;

			kind_s3 <= kind_s2;
			kb_s3   <= kb_s2;
			mre_s3  <= mre_s2;
			mim_s3  <= mim_s2;

			kind_s4 <= kind_s3;
			kb_s4   <= kb_s3;
			mre_s4  <= mre_s3;
			mim_s4  <= mim_s3;
		end
	end

	logic [AXW-1:0] row_s4, col_s4;

	sqmd_axis #(.SAMPLE_WIDTH(SW), .FRAC_BITS(FRAC_BITS)) u_row (
		.clk(clk), .en(en), .kb_sel(kb_s1), .smp(re_s1), .idx(row_s4)
	);

	sqmd_axis #(.SAMPLE_WIDTH(SW), .FRAC_BITS(FRAC_BITS)) u_col (
		.clk(clk), .en(en), .kb_sel(kb_s1), .smp(im_s1), .idx(col_s4)
	);

	// decided index, row then column
	logic [5:0] sym_out;
	assign sym_out = (kind_s4 == sqmd_pkg::KIND_DEMAP)
		? ((6'(row_s4) << ({1'b0, kb_s4} + 3'd1)) | 6'(col_s4)) : 6'd0;

	assign m_tdata = DW'({sym_out, mim_s4, mre_s4});

	// a map word never carries an index
	a_map_sym: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind_s4 == sqmd_pkg::KIND_MAP |-> m_tdata[2*SW +: 6] == 6'd0)
		else $error("map word with nonzero index");

	// a demap word never carries coordinates
	a_demap_pt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind_s4 == sqmd_pkg::KIND_DEMAP |-> m_tdata[2*SW-1:0] == '0)
		else $error("demap word with nonzero point");

	// a stalled output word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pipeline moved during stall");

	// ready follows the output stage
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!v_s4 || m_tready))
		else $error("ready not tied to output stage");

endmodule
